[hw/rtl/bfdp_pkg.sv]
// ----------------------------------------------------------------------------
// bfdp_pkg
// shared constants, result type and helpers for the brace frame parser
// ----------------------------------------------------------------------------
package bfdp_pkg;

    localparam int NUM_FIELDS_DEF      = 5;
    localparam int CHARS_PER_FIELD_DEF = 3;

    // fixed layout: field 0 is the tag, fields 1 to 4 are numeric
    localparam int NUM_VALUES = 4;
    localparam int PAD_FIELDS = NUM_VALUES + 1;
    localparam int PAD_CHARS  = 3;

    localparam logic [7:0] CH_OPEN   = 8'h7b;
    localparam logic [7:0] CH_CLOSE  = 8'h7d;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_V      = 8'h56;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_O      = 8'h4f;
    localparam logic [7:0] CH_K      = 8'h4b;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;

    localparam logic [3:0] MASK_O    = 4'h1;
    localparam logic [3:0] MASK_K    = 4'h2;
    localparam logic [3:0] MASK_CR   = 4'h4;
    localparam logic [3:0] MASK_LF   = 4'h8;
    localparam logic [3:0] KEEP_K    = 4'hd;
    localparam logic [3:0] KEEP_CR   = 4'hb;
    localparam logic [3:0] KEEP_LF   = 4'h7;
    localparam logic [3:0] MASK_FULL = 4'hf;

    typedef logic [PAD_CHARS-1:0][7:0] field_chars_t;

    typedef struct packed {
        logic                       frame_done;
        logic                       var_frame;
        logic                       ok_ack;
        logic [NUM_VALUES-1:0][7:0] values;
    } result_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

[hw/rtl/bfdp_field_decode.sv]
// ----------------------------------------------------------------------------
// bfdp_field_decode
// turns up to three stored characters into a byte, keeps old value if no digit
// ----------------------------------------------------------------------------
module bfdp_field_decode
    import bfdp_pkg::*;
(
    input  field_chars_t chars,
    input  logic [7:0]   old_value,
    output logic [7:0]   new_value
);

    logic [7:0] off0;
    logic [7:0] off1;
    logic [7:0] off2;

    // offsets wrap mod 256, leading positions are not checked
    assign off0 = chars[0] - CH_ZERO;
    assign off1 = chars[1] - CH_ZERO;
    assign off2 = chars[2] - CH_ZERO;

    always_comb
    begin
        if (is_digit(chars[2]))
        begin
            new_value = 8'(off0 * 8'd100) + 8'(off1 * 8'd10) + off2;
        end
        else if (is_digit(chars[1]))
        begin
            new_value = 8'(off0 * 8'd10) + off1;
        end
        else if (is_digit(chars[0]))
        begin
            new_value = off0;
        end
        else
        begin
            new_value = old_value;
        end
    end

endmodule

[hw/rtl/bfdp_parser_core.sv]
// ----------------------------------------------------------------------------
// bfdp_parser_core
// parser state: character store, indices, frame flag, ack mask, values
// ----------------------------------------------------------------------------
module bfdp_parser_core
    import bfdp_pkg::*;
#(
    parameter int NUM_FIELDS      = NUM_FIELDS_DEF,
    parameter int CHARS_PER_FIELD = CHARS_PER_FIELD_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    output result_t    result
);

    localparam int FIW = $clog2(NUM_FIELDS + 1);

    logic [NUM_FIELDS-1:0][CHARS_PER_FIELD-1:0][7:0] store_reg;
    logic [FIW-1:0]                 field_index_reg, field_index_next;
    logic [1:0]                     char_index_reg, char_index_next;
    logic                           in_frame_reg, in_frame_next;
    logic [3:0]                     ok_mask_reg, ok_mask_next;
    logic [NUM_VALUES-1:0][7:0]     values_reg, values_next;

    logic [PAD_FIELDS-1:0][PAD_CHARS-1:0][7:0] pad;
    logic [NUM_VALUES-1:0][7:0]     decoded;
    logic                           store_we;
    logic                           store_clear;
    logic                           is_var;
    logic [3:0]                     mask_upd;

    // missing fields and positions read as zero bytes (8'h00)
    for (genvar f = 0; f < PAD_FIELDS; f++)
    begin : g_pad_f
        for (genvar j = 0; j < PAD_CHARS; j++)
        begin : g_pad_c
            if (f < NUM_FIELDS && j < CHARS_PER_FIELD)
            begin : g_real
                assign pad[f][j] = store_reg[f][j];
            end
            else
            begin : g_zero
                assign pad[f][j] = 8'h00;
            end
        end
    end

    for (genvar v = 0; v < NUM_VALUES; v++)
    begin : g_dec
        bfdp_field_decode u_dec
        (
            .chars     (pad[v + 1]),
            .old_value (values_reg[v]),
            .new_value (decoded[v])
        );
    end

    assign is_var = (pad[0][0] == CH_V) && (pad[0][1] == CH_A) && (pad[0][2] == CH_R);

    always_comb
    begin
        field_index_next = field_index_reg;
        char_index_next  = char_index_reg;
        in_frame_next    = in_frame_reg;
        ok_mask_next     = ok_mask_reg;
        values_next      = values_reg;
        store_we         = 1'b0;
        store_clear      = 1'b0;
        result.frame_done = 1'b0;
        result.var_frame  = 1'b0;
        result.ok_ack     = 1'b0;
        mask_upd          = ok_mask_reg;

        if (rx_byte == CH_OPEN)
        begin
            field_index_next = '0;
            char_index_next  = '0;
            in_frame_next    = 1'b1;
        end
        else if (rx_byte == CH_CLOSE)
        begin
            in_frame_next     = 1'b0;
            result.frame_done = 1'b1;
            if (is_var)
            begin
                values_next      = decoded;
                store_clear      = 1'b1;
                result.var_frame = 1'b1;
            end
        end
        else if (rx_byte == CH_COLON || rx_byte == CH_COMMA)
        begin
            // separators advance even outside a frame
            if (field_index_reg < FIW'(NUM_FIELDS))
            begin
                field_index_next = field_index_reg + 1'b1;
            end
            char_index_next = '0;
        end
        else if (in_frame_reg)
        begin
            store_we = (char_index_reg < 2'(CHARS_PER_FIELD))
                       && (field_index_reg < FIW'(NUM_FIELDS));
            if (char_index_reg != 2'd3)
            begin
                char_index_next = char_index_reg + 1'b1;
            end
        end
        else
        begin
            case (rx_byte)
                CH_O:    mask_upd = MASK_O;
                CH_K:    mask_upd = (ok_mask_reg & KEEP_K) | MASK_K;
                CH_CR:   mask_upd = (ok_mask_reg & KEEP_CR) | MASK_CR;
                CH_LF:   mask_upd = (ok_mask_reg & KEEP_LF) | MASK_LF;
                default: mask_upd = ok_mask_reg;
            endcase
            if (mask_upd == MASK_FULL)
            begin
                result.ok_ack = 1'b1;
                ok_mask_next  = '0;
            end
            else
            begin
                ok_mask_next = mask_upd;
            end
        end

        result.values = values_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_index_reg <= '0;
            char_index_reg  <= '0;
            in_frame_reg    <= 1'b0;
            ok_mask_reg     <= '0;
            values_reg      <= '0;
            store_reg       <= '0;
        end
        else if (step)
        begin
            field_index_reg <= field_index_next;
            char_index_reg  <= char_index_next;
            in_frame_reg    <= in_frame_next;
            ok_mask_reg     <= ok_mask_next;
            values_reg      <= values_next;
            for (int f = 0; f < NUM_FIELDS; f++)
            begin
                for (int j = 0; j < CHARS_PER_FIELD; j++)
                begin
                    if (store_clear)
                    begin
                        store_reg[f][j] <= 8'h00;
                    end
                    else if (store_we && field_index_reg == FIW'(f)
                             && char_index_reg == 2'(j))
                    begin
                        store_reg[f][j] <= rx_byte;
                    end
                end
            end
        end
    end

endmodule

[hw/rtl/brace_frame_decimal_parser.sv]
// ----------------------------------------------------------------------------
// brace_frame_decimal_parser
// byte stream parser for {VAR:a,b,c,d} frames and OK CR LF acknowledges
// ----------------------------------------------------------------------------
// One received byte goes in per word on the slave side and exactly one result
// word comes out per byte. The block sustains one byte per clock cycle while
// m_axis_tready stays high. An accepted byte is held in the input register; it
// passes to the parser once the result register is free or draining, and that
// edge updates the parser state and loads the result register together, so a
// stalled result stream holds the byte in the input register.
// A '{' opens a frame, ':' and ',' step to the next field, and up to
// CHARS_PER_FIELD characters per field are kept. On '}' the frame is reported;
// if field 0 reads VAR the four numeric fields are decoded to bytes (mod 256,
// empty fields keep their value) and the character store is cleared. Outside
// a frame the letters O, K, CR, LF are tracked and reported once K, CR and LF
// all follow the last O. The decoded values are present on every result word.
// ----------------------------------------------------------------------------
module brace_frame_decimal_parser
    import bfdp_pkg::*;
#(
    parameter int NUM_FIELDS      = NUM_FIELDS_DEF,
    parameter int CHARS_PER_FIELD = CHARS_PER_FIELD_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // value_a, value_b, value_c, value_d
    output logic [2:0]  m_axis_tuser    // frame_done, var_frame, ok_ack
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    core_result;
    logic       advance;

    // a byte moves into the parser when the result register is free or drains
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    bfdp_parser_core #(
        .NUM_FIELDS      (NUM_FIELDS),
        .CHARS_PER_FIELD (CHARS_PER_FIELD)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .result  (core_result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= core_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.values[3], out_reg.values[2],
                            out_reg.values[1], out_reg.values[0]};
    assign m_axis_tuser  = {out_reg.ok_ack, out_reg.var_frame, out_reg.frame_done};

endmodule
